// ===== sv/smpq_pkg.sv =====
`timescale 1ns / 1ps

package smpq_pkg;

  // queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned KeyW       = 32;
  localparam int unsigned TagW       = 32;
  localparam int unsigned FillW      = 5;

  // operation codes carried in the input tuser
  typedef enum logic {
    KindInsert = 1'b0,
    KindRemove = 1'b1
  } kind_e;

  // result status codes carried in the output tuser
  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnderflow = 2'd1,
    StFull      = 2'd2
  } status_e;

  // one stored entry
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } cell_op_t;

endpackage

// ===== sv/stable_max_priority_queue.sv =====
`timescale 1ns / 1ps
// a result appears in the output register in the cycle after its item is accepted
// throughput: one item per cycle while the input is not stalled; every cell of the chain updates in the same edge
// the input is stalled only while a finished result waits and m_axis_tready_i is low
// reset: rst_ni is asynchronous, active low; it empties the queue and the output register
// entry contents are not cleared, only the fill count is

module stable_max_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // price_key, record_tag
  input  logic        s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // out_key, out_tag, fill_level, zero pad
  output logic [1:0]  m_axis_tuser_o    // status
);

  localparam int unsigned Depth  = smpq_pkg::QueueDepth;
  localparam int unsigned CountW = smpq_pkg::CountW;
  localparam int unsigned FillW  = smpq_pkg::FillW;

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  logic [71:0]       out_data_q, out_data_d;
  logic [1:0]        out_user_q, out_user_d;

  logic              accept;
  logic              is_remove;
  logic              full;
  logic              empty;
  smpq_pkg::cell_op_t op;
  smpq_pkg::status_e status;
  smpq_pkg::entry_t  in_entry;
  smpq_pkg::entry_t  res_entry;
  logic [CountW+FillW-1:0] count_ext;

  logic             ge   [Depth];
  smpq_pkg::entry_t ents [Depth];

  // handshake: the output register parts the two sides
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_remove       = (s_axis_tuser_i == smpq_pkg::KindRemove);

  assign in_entry.key = s_axis_tdata_i[31:0];
  assign in_entry.tag = s_axis_tdata_i[63:32];

  assign full  = (count_q == CountW'(Depth));
  assign empty = (count_q == '0);

  // operation for the cell chain
  always_comb begin
    op.entry = in_entry;
    op.ins   = accept && !is_remove && !full;
    op.rem   = accept && is_remove && !empty;
  end

  // cell chain, front at index zero
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    localparam logic [CountW-1:0] Idx = CountW'(g);
    logic             prev_ge;
    smpq_pkg::entry_t prev_ent;
    smpq_pkg::entry_t next_ent;

    if (g == 0) begin : g_first
      assign prev_ge  = 1'b1;
      assign prev_ent = in_entry;
    end else begin : g_mid
      assign prev_ge  = ge[g-1];
      assign prev_ent = ents[g-1];
    end

    if (g == Depth - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ents[g+1];
    end

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .valid_i      (count_q > Idx),
      .prev_ge_i    (prev_ge),
      .prev_entry_i (prev_ent),
      .next_entry_i (next_ent),
      .ge_o         (ge[g]),
      .entry_o      (ents[g])
    );
  end

  // status, removed entry and new fill count
  always_comb begin
    status    = smpq_pkg::StOk;
    res_entry = '0;
    count_d   = count_q;
    if (is_remove) begin
      if (empty) begin
        status = smpq_pkg::StUnderflow;
      end else begin
        res_entry = ents[0];
        count_d   = count_q - CountW'(1);
      end
    end else begin
      if (full) begin
        status = smpq_pkg::StFull;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end
    count_ext  = {{FillW{1'b0}}, count_d};
    out_data_d = {3'b000, count_ext[FillW-1:0], res_entry.tag, res_entry.key};
    out_user_d = status;
  end

  // fill count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (s_axis_tready_o) begin
        out_valid_q <= accept;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== sv/smpq_cell.sv =====
`timescale 1ns / 1ps

module smpq_cell (
  input  logic              clk_i,
  input  smpq_pkg::cell_op_t op_i,
  input  logic              valid_i,
  input  logic              prev_ge_i,
  input  smpq_pkg::entry_t  prev_entry_i,
  input  smpq_pkg::entry_t  next_entry_i,
  output logic              ge_o,
  output smpq_pkg::entry_t  entry_o
);

  smpq_pkg::entry_t entry_q, entry_d;

  // held entry ranks at or ahead of the incoming key
  assign ge_o    = valid_i && (entry_q.key >= op_i.entry.key);
  assign entry_o = entry_q;

  // keep, take the new entry, shift from behind or shift from ahead
  always_comb begin
    entry_d = entry_q;
    if (op_i.ins) begin
      if (!ge_o) begin
        entry_d = prev_ge_i ? op_i.entry : prev_entry_i;
      end
    end else if (op_i.rem) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
